/* src/crc8_pkg.sv */
package crc8_pkg;

  localparam logic       CMD_ENCODE  = 1'b0;
  localparam logic       CMD_CHECK   = 1'b1;
  localparam logic [7:0] POLY_RESET  = 8'h07;
  localparam int         QUEUE_DEPTH = 4;

  typedef struct packed {
    logic cmd;
    logic in_bit;
    logic in_last;
  } in_item_t;

  typedef struct packed {
    logic out_bit;
    logic is_check;
    logic crc_error;
    logic out_last;
  } out_item_t;

  typedef struct packed {
    logic bit_val;
    logic is_check;
    logic crc_error;
    logic tail;
  } job_t;

endpackage

/* src/crc8_bit_serial_encode_check.sv */
// Bit-serial CRC encoder and checker (MSB first, zero initial remainder, no
// reflection, no final XOR). One input item, a single bit, is taken every
// cycle while the internal queue has room. In encode mode each item yields one
// output item, and an item marked last yields CRC_WIDTH more, which the output
// stage sends one per cycle unless out_stall holds it; in check mode only the
// last item yields a verdict. Output is therefore paced at one item per cycle
// by the output register while out_stall is low, and input stalls only when
// the four-entry queue between remainder update and output serializer fills,
// which happens during a remainder tail or while the output side is stalled.
// The polynomial register resets to 0x07 and is written through the cfg port,
// which is always ready; write it only while the block is idle.
module crc8_bit_serial_encode_check #(
  parameter int CRC_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  crc8_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output crc8_pkg::out_item_t out_item
);

  localparam int JOB_W = $bits(crc8_pkg::job_t) + CRC_WIDTH;

  logic                 job_push, job_pop, q_full, q_avail;
  crc8_pkg::job_t       push_job, pop_job;
  logic [CRC_WIDTH-1:0] push_rem, pop_rem;
  logic [JOB_W-1:0]     q_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign pop_job   = crc8_pkg::job_t'(q_out[JOB_W-1:CRC_WIDTH]);
  assign pop_rem   = q_out[CRC_WIDTH-1:0];

  crc8_front #(.CRC_WIDTH(CRC_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .job_push (job_push),
    .job      (push_job),
    .job_rem  (push_rem)
  );

  crc8_fifo #(.WIDTH(JOB_W), .DEPTH(crc8_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data({push_job, push_rem}),
    .full     (q_full),
    .pop      (job_pop),
    .pop_data (q_out),
    .not_empty(q_avail)
  );

  crc8_back #(.CRC_WIDTH(CRC_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_avail(q_avail),
    .job      (pop_job),
    .job_rem  (pop_rem),
    .job_pop  (job_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

/* src/crc8_fifo.sv */
module crc8_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/crc8_front.sv */
module crc8_front #(
  parameter int CRC_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  crc8_pkg::in_item_t   in_item,
  output logic                 job_push,
  output crc8_pkg::job_t       job,
  output logic [CRC_WIDTH-1:0] job_rem
);

  logic [7:0]           poly_r, poly_nxt;
  logic [CRC_WIDTH-1:0] poly_w;
  logic [CRC_WIDTH-1:0] rem_r, rem_nxt;
  logic [CRC_WIDTH-1:0] rem_shl, rem_shifted, rem_upd;
  logic                 top, xor_en, accept, is_chk;

  if (CRC_WIDTH == 8) begin : g_poly_eq
    assign poly_w = poly_r;
  end else if (CRC_WIDTH > 8) begin : g_poly_wide
    assign poly_w = {{(CRC_WIDTH - 8){1'b0}}, poly_r};
  end else begin : g_poly_narrow
    assign poly_w = poly_r[CRC_WIDTH-1:0];
  end

  assign accept  = in_valid && !in_stall;
  assign is_chk  = (in_item.cmd == crc8_pkg::CMD_CHECK);
  assign top     = rem_r[CRC_WIDTH-1];
  assign rem_shl = rem_r << 1;

  always_comb begin
    if (is_chk) begin
      rem_shifted = rem_shl | CRC_WIDTH'(in_item.in_bit);
      xor_en      = top;
    end else begin
      rem_shifted = rem_shl;
      xor_en      = in_item.in_bit ^ top;
    end
    rem_upd = xor_en ? (rem_shifted ^ poly_w) : rem_shifted;

    rem_nxt = rem_r;
    if (accept) begin
      rem_nxt = in_item.in_last ? '0 : rem_upd;
    end
    poly_nxt = cfg_valid ? cfg_data : poly_r;

    job_push      = accept && (!is_chk || in_item.in_last);
    job.bit_val   = is_chk ? 1'b0 : in_item.in_bit;
    job.is_check  = is_chk;
    job.crc_error = is_chk && (rem_upd != '0);
    job.tail      = !is_chk && in_item.in_last;
    job_rem       = rem_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= crc8_pkg::POLY_RESET;
      rem_r  <= '0;
    end else begin
      poly_r <= poly_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

/* src/crc8_back.sv */
module crc8_back #(
  parameter int CRC_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_avail,
  input  crc8_pkg::job_t       job,
  input  logic [CRC_WIDTH-1:0] job_rem,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crc8_pkg::out_item_t  out_item
);

  localparam int CNT_W = $clog2(CRC_WIDTH + 1);

  logic                      valid_r, valid_nxt;
  crc8_pkg::out_item_t       item_r, item_nxt;
  logic [CRC_WIDTH-1:0]      sh_r, sh_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      adv;

  assign adv       = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    job_pop   = 1'b0;
    if (adv) begin
      if (cnt_r != '0) begin
        valid_nxt          = 1'b1;
        item_nxt.out_bit   = sh_r[CRC_WIDTH-1];
        item_nxt.is_check  = 1'b0;
        item_nxt.crc_error = 1'b0;
        item_nxt.out_last  = (cnt_r == CNT_W'(1));
        sh_nxt             = sh_r << 1;
        cnt_nxt            = cnt_r - 1'b1;
      end else if (job_avail) begin
        job_pop            = 1'b1;
        valid_nxt          = 1'b1;
        item_nxt.out_bit   = job.bit_val;
        item_nxt.is_check  = job.is_check;
        item_nxt.crc_error = job.crc_error;
        item_nxt.out_last  = job.is_check;
        sh_nxt             = job_rem;
        cnt_nxt            = job.tail ? CNT_W'(CRC_WIDTH) : '0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    sh_r   <= sh_nxt;
  end

endmodule
